// ----- rtl/core/aft_pkg.sv -----
// ----------------------------------------------------------------------------
// aft_pkg: shared types and constants for the alert flash timer
// Register indexes, reset values, beat payload structs and the saturating
// counter helper.
// ----------------------------------------------------------------------------
`default_nettype none

package aft_pkg;

	localparam int CNT_W     = 16;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int IN_DATA_W = 56;
	localparam int OUT_DATA_W = 32;

	localparam logic [CNT_W-1:0]  CNT_MAX     = 16'hFFFF;
	localparam logic [BYTE_W-1:0] MIN_PKT_LEN = 8'd6;

	// register reset values
	localparam logic [CNT_W-1:0]  RST_COOLDOWN  = 16'd1000;
	localparam logic [CNT_W-1:0]  RST_ON        = 16'd200;
	localparam logic [CNT_W-1:0]  RST_OFF       = 16'd200;
	localparam logic [CNT_W-1:0]  RST_HEARTBEAT = 16'd2000;
	localparam logic [BYTE_W-1:0] RST_ALERT_TYPE = 8'h01;
	localparam logic [3*BYTE_W-1:0] RST_COLOUR  = 24'hFFFFFF;

	// input command codes
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_PACKET = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COOLDOWN  = 3'd0,
		REG_ON        = 3'd1,
		REG_OFF       = 3'd2,
		REG_HEARTBEAT = 3'd3,
		REG_ALERT_TYPE = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]  cooldown_ticks;
		logic [CNT_W-1:0]  on_ticks;
		logic [CNT_W-1:0]  off_ticks;
		logic [CNT_W-1:0]  heartbeat_ticks;
		logic [BYTE_W-1:0] alert_type;
	} cfg_t;

	typedef struct packed {
		logic              command;
		logic [BYTE_W-1:0] pkt_len;
		logic [BYTE_W-1:0] msg_type;
		logic [CNT_W-1:0]  duration_ticks;
		logic [BYTE_W-1:0] red_in;
		logic [BYTE_W-1:0] green_in;
		logic [BYTE_W-1:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red_out;
		logic [BYTE_W-1:0] green_out;
		logic [BYTE_W-1:0] blue_out;
		logic              motor_on;
		logic              heartbeat_on;
		logic              is_flashing;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/aft_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// aft_cfg_regs: configuration register file
// Write-only registers loaded from the plain write port; unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module aft_cfg_regs
	import aft_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cooldown_ticks  <= RST_COOLDOWN;
			cfg_q.on_ticks        <= RST_ON;
			cfg_q.off_ticks       <= RST_OFF;
			cfg_q.heartbeat_ticks <= RST_HEARTBEAT;
			cfg_q.alert_type      <= RST_ALERT_TYPE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COOLDOWN:   cfg_q.cooldown_ticks  <= cfg_wdata;
				REG_ON:         cfg_q.on_ticks        <= cfg_wdata;
				REG_OFF:        cfg_q.off_ticks       <= cfg_wdata;
				REG_HEARTBEAT:  cfg_q.heartbeat_ticks <= cfg_wdata;
				REG_ALERT_TYPE: cfg_q.alert_type      <= cfg_wdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/aft_engine.sv -----
// ----------------------------------------------------------------------------
// aft_engine: flash, cooldown and heartbeat state update
// Holds the timer state and updates it for one beat per step; the result
// reflects the state after that beat.
// ----------------------------------------------------------------------------
`default_nettype none

module aft_engine
	import aft_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_item_t item,
	input  wire cfg_t     cfg,
	output result_t       result
);

	logic                flash_active_q, flash_active_d;
	logic                lights_lit_q, lights_lit_d;
	logic [CNT_W-1:0]    flash_elapsed_q, flash_elapsed_d;
	logic [CNT_W-1:0]    phase_count_q, phase_count_d;
	logic [CNT_W-1:0]    flash_length_q, flash_length_d;
	logic [3*BYTE_W-1:0] colour_q, colour_d;
	logic [CNT_W-1:0]    since_accept_q, since_accept_d;
	logic [CNT_W-1:0]    since_hb_q, since_hb_d;
	logic                hb_state_q, hb_state_d;
	logic                pkt_ok;
	logic                shown;

	// packet qualification
	assign pkt_ok = (item.command == CMD_PACKET) && (item.pkt_len >= MIN_PKT_LEN) &&
		(item.msg_type == cfg.alert_type) && (since_accept_q >= cfg.cooldown_ticks);

	// next state for one beat
	always_comb begin
		flash_active_d  = flash_active_q;
		lights_lit_d    = lights_lit_q;
		flash_elapsed_d = flash_elapsed_q;
		phase_count_d   = phase_count_q;
		flash_length_d  = flash_length_q;
		colour_d        = colour_q;
		since_accept_d  = since_accept_q;
		since_hb_d      = since_hb_q;
		hb_state_d      = hb_state_q;
		if (item.command == CMD_PACKET) begin
			if (pkt_ok) begin
				since_accept_d  = '0;
				flash_length_d  = item.duration_ticks;
				colour_d        = {item.red_in, item.green_in, item.blue_in};
				flash_elapsed_d = '0;
				phase_count_d   = '0;
				if (item.duration_ticks == '0) begin
					flash_active_d = 1'b0;
					lights_lit_d   = 1'b0;
				end else begin
					flash_active_d = 1'b1;
					lights_lit_d   = 1'b1;
					hb_state_d     = 1'b0;
				end
			end
		end else begin
			since_accept_d = sat_inc(since_accept_q);
			since_hb_d     = sat_inc(since_hb_q);
			if (flash_active_q) begin
				flash_elapsed_d = sat_inc(flash_elapsed_q);
				phase_count_d   = sat_inc(phase_count_q);
				if (flash_elapsed_d >= flash_length_q) begin
					flash_active_d = 1'b0;
					lights_lit_d   = 1'b0;
				end else if (lights_lit_q && phase_count_d >= cfg.on_ticks) begin
					lights_lit_d  = 1'b0;
					phase_count_d = '0;
				end else if (!lights_lit_q && phase_count_d >= cfg.off_ticks) begin
					lights_lit_d  = 1'b1;
					phase_count_d = '0;
				end
			end
			// heartbeat runs only while idle, including the tick that ends a flash
			if (!flash_active_d && since_hb_d >= cfg.heartbeat_ticks) begin
				hb_state_d = !hb_state_q;
				since_hb_d = '0;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_active_q  <= 1'b0;
			lights_lit_q    <= 1'b0;
			flash_elapsed_q <= '0;
			phase_count_q   <= '0;
			flash_length_q  <= '0;
			colour_q        <= RST_COLOUR;
			since_accept_q  <= '0;
			since_hb_q      <= '0;
			hb_state_q      <= 1'b0;
		end else if (step) begin
			flash_active_q  <= flash_active_d;
			lights_lit_q    <= lights_lit_d;
			flash_elapsed_q <= flash_elapsed_d;
			phase_count_q   <= phase_count_d;
			flash_length_q  <= flash_length_d;
			colour_q        <= colour_d;
			since_accept_q  <= since_accept_d;
			since_hb_q      <= since_hb_d;
			hb_state_q      <= hb_state_d;
		end
	end

	// result seen after this beat
	assign shown = flash_active_d && lights_lit_d;

	always_comb begin
		result.red_out      = shown ? colour_d[3*BYTE_W-1:2*BYTE_W] : '0;
		result.green_out    = shown ? colour_d[2*BYTE_W-1:BYTE_W] : '0;
		result.blue_out     = shown ? colour_d[BYTE_W-1:0] : '0;
		result.motor_on     = shown;
		result.heartbeat_on = hb_state_d && !flash_active_d;
		result.is_flashing  = flash_active_d;
	end

`ifndef SYNTHESIS
	// lights are only lit inside a flash
	a_lit_needs_flash: assert property (@(posedge clk) disable iff (!arst_n)
		!flash_active_q |-> !lights_lit_q)
		else $error("lights lit with no flash running");

	// a running flash has not yet reached its length
	a_flash_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		flash_active_q |-> (flash_elapsed_q < flash_length_q))
		else $error("flash running past its length");

	// heartbeat stays dark through a flash
	a_hb_dark_in_flash: assert property (@(posedge clk) disable iff (!arst_n)
		flash_active_q |-> !hb_state_q)
		else $error("heartbeat state set during flash");

	// an accepted packet restarts the cooldown
	a_cooldown_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pkt_ok) |=> (since_accept_q == '0))
		else $error("cooldown not restarted after accepted packet");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/alert_flash_timer_unit.sv -----
// ----------------------------------------------------------------------------
// alert_flash_timer_unit: alert flash and heartbeat timer
// Streams ticks and alert packets in and one status beat out per input beat.
// ----------------------------------------------------------------------------
// Each input beat (tuser 0 = one-millisecond tick, 1 = received packet) gives
// exactly one output beat with the LED colour, motor, heartbeat and flash
// status after that beat. The unit takes one beat per clock unless the output
// stalls; a beat passes an input register, then the state update and the result
// register, and consecutive beats never wait on each other. The user must write
// configuration through the cfg port only while idle; not enforced by the block.
// ----------------------------------------------------------------------------
`default_nettype none

module alert_flash_timer_unit
	import aft_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// slave stream
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// tdata: pkt_len, msg_type, duration_ticks, red_in, green_in, blue_in
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: command
	input  wire logic                  s_axis_tuser,
	// master stream
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// tdata: red_out, green_out, blue_out, motor_on, heartbeat_on, is_flashing, zero pad
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DAT_W-1:0]  cfg_wdata
);

	cfg_t     cfg;
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	result_t  result;
	result_t  result_q;
	logic     out_valid_q;

	aft_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// beat moves from stage 1 into the result register
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.command        <= s_axis_tuser;
			item_s1.pkt_len        <= s_axis_tdata[7:0];
			item_s1.msg_type       <= s_axis_tdata[15:8];
			item_s1.duration_ticks <= s_axis_tdata[31:16];
			item_s1.red_in         <= s_axis_tdata[39:32];
			item_s1.green_in       <= s_axis_tdata[47:40];
			item_s1.blue_in        <= s_axis_tdata[55:48];
		end
	end

	aft_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, result_q.is_flashing, result_q.heartbeat_on,
		result_q.motor_on, result_q.blue_out, result_q.green_out, result_q.red_out};

endmodule

`default_nettype wire

// ----- verif/aft_status_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aft_status_checker: status beat checker for the alert flash timer
// Watches the input stream and the register port, keeps its own copy of the
// timer state and registers, works out the status beat each input beat causes
// and compares every output beat field by field, oldest prediction first.
// ----------------------------------------------------------------------------

module aft_status_checker
	import aft_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	// tdata: pkt_len, msg_type, duration_ticks, red_in, green_in, blue_in
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: command
	input  wire logic                  s_axis_tuser,
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// tdata: red_out, green_out, blue_out, motor_on, heartbeat_on, is_flashing, zero pad
	input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DAT_W-1:0]  cfg_wdata,
	output int                         mismatches,
	output int                         pending
);

	// register copy
	logic [CNT_W-1:0]    cooldown_q;
	logic [CNT_W-1:0]    on_q;
	logic [CNT_W-1:0]    off_q;
	logic [CNT_W-1:0]    hb_period_q;
	logic [BYTE_W-1:0]   alert_type_q;

	// timer state copy
	logic                flashing;
	logic                lit;
	logic [CNT_W-1:0]    elapsed;
	logic [CNT_W-1:0]    phase;
	logic [CNT_W-1:0]    flash_len;
	logic [3*BYTE_W-1:0] colour;
	logic [CNT_W-1:0]    since_alert;
	logic [CNT_W-1:0]    since_beat;
	logic                hb_lit;

	result_t             status_q[$];
	in_item_t            beat_in;
	result_t             want;

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

	// one millisecond tick: counters, flash phase, heartbeat
	task automatic apply_tick();
		since_alert = count_up(since_alert);
		since_beat  = count_up(since_beat);
		if (flashing) begin
			elapsed = count_up(elapsed);
			phase   = count_up(phase);
			if (elapsed >= flash_len) begin
				flashing = 1'b0;
				lit      = 1'b0;
			end else if (lit && phase >= on_q) begin
				lit   = 1'b0;
				phase = '0;
			end else if (!lit && phase >= off_q) begin
				lit   = 1'b1;
				phase = '0;
			end
		end
		// heartbeat only runs while idle, also on the tick that ends a flash
		if (!flashing && since_beat >= hb_period_q) begin
			hb_lit     = !hb_lit;
			since_beat = '0;
		end
	endtask

	// received packet: filter, then latch and restart the flash
	task automatic apply_packet(input in_item_t p);
		if (p.pkt_len < MIN_PKT_LEN || p.msg_type != alert_type_q || since_alert < cooldown_q)
			return;
		since_alert = '0;
		flash_len   = p.duration_ticks;
		colour      = {p.red_in, p.green_in, p.blue_in};
		elapsed     = '0;
		phase       = '0;
		if (flash_len == '0) begin
			// zero duration: latched but over at once
			flashing = 1'b0;
			lit      = 1'b0;
		end else begin
			flashing = 1'b1;
			lit      = 1'b1;
			hb_lit   = 1'b0;
		end
	endtask

	function automatic result_t status_now();
		result_t r;
		logic    shown;
		shown          = flashing && lit;
		r.red_out      = shown ? colour[23:16] : '0;
		r.green_out    = shown ? colour[15:8]  : '0;
		r.blue_out     = shown ? colour[7:0]   : '0;
		r.motor_on     = shown;
		r.heartbeat_on = hb_lit && !flashing;
		r.is_flashing  = flashing;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v, act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q   = RST_COOLDOWN;
			on_q         = RST_ON;
			off_q        = RST_OFF;
			hb_period_q  = RST_HEARTBEAT;
			alert_type_q = RST_ALERT_TYPE;
			flashing     = 1'b0;
			lit          = 1'b0;
			elapsed      = '0;
			phase        = '0;
			flash_len    = '0;
			colour       = RST_COLOUR;
			since_alert  = '0;
			since_beat   = '0;
			hb_lit       = 1'b0;
			mismatches   = 0;
			status_q.delete();
		end else begin
			// register writes must happen only while the unit is idle; nothing here enforces it
			if (cfg_we) begin
				case (cfg_index)
					REG_COOLDOWN:   cooldown_q   = cfg_wdata;
					REG_ON:         on_q         = cfg_wdata;
					REG_OFF:        off_q        = cfg_wdata;
					REG_HEARTBEAT:  hb_period_q  = cfg_wdata;
					REG_ALERT_TYPE: alert_type_q = cfg_wdata[BYTE_W-1:0];
					default: ;
				endcase
			end
			// predict one status beat per accepted input beat
			if (s_axis_tvalid && s_axis_tready) begin
				beat_in.command        = s_axis_tuser;
				beat_in.pkt_len        = s_axis_tdata[7:0];
				beat_in.msg_type       = s_axis_tdata[15:8];
				beat_in.duration_ticks = s_axis_tdata[31:16];
				beat_in.red_in         = s_axis_tdata[39:32];
				beat_in.green_in       = s_axis_tdata[47:40];
				beat_in.blue_in        = s_axis_tdata[55:48];
				if (beat_in.command == CMD_PACKET)
					apply_packet(beat_in);
				else
					apply_tick();
				status_q.push_back(status_now());
			end
			// compare each accepted status beat with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (status_q.size() == 0) begin
					$error("status beat %h with no prediction waiting", m_axis_tdata);
					mismatches++;
				end else begin
					want = status_q.pop_front();
					check_field("red_out", 32'(want.red_out), 32'(m_axis_tdata[7:0]));
					check_field("green_out", 32'(want.green_out), 32'(m_axis_tdata[15:8]));
					check_field("blue_out", 32'(want.blue_out), 32'(m_axis_tdata[23:16]));
					check_field("motor_on", 32'(want.motor_on), 32'(m_axis_tdata[24]));
					check_field("heartbeat_on", 32'(want.heartbeat_on),
						32'(m_axis_tdata[25]));
					check_field("is_flashing", 32'(want.is_flashing), 32'(m_axis_tdata[26]));
					check_field("pad", 0, 32'(m_axis_tdata[31:27]));
				end
			end
		end
		pending = status_q.size();
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for the alert flash timer
// Drives ticks and alert packets with bursty valid and a stalling receiver,
// walks through several register settings and a closing tick run past a
// flash and a cooldown; the checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------

module tb;
	import aft_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int PHASE_BEATS = 310;
	localparam int SOAK_TICKS  = 40;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DAT_W-1:0]  cfg_wdata;

	int                    status_errors;
	int                    status_pending;
	int                    burst_left;
	bit                    hold_req;
	logic [BYTE_W-1:0]     cur_type;
	int                    ph;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	alert_flash_timer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	aft_status_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (status_errors),
		.pending       (status_pending)
	);

	// offer one beat; bursts of random length with random gaps between them
	task automatic send_beat(input in_item_t it);
		int r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			r = $urandom_range(0, 9);
			gap = (r < 5) ? 0 : (r < 8) ? $urandom_range(1, 3) : $urandom_range(4, 20);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.command;
		s_axis_tdata  <= {it.blue_in, it.green_in, it.red_in, it.duration_ticks,
			it.msg_type, it.pkt_len};
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
	endtask

	// tick with random don't-care payload
	task automatic send_tick();
		in_item_t it;
		it.command        = CMD_TICK;
		it.pkt_len        = BYTE_W'($urandom_range(0, 250));
		it.msg_type       = BYTE_W'($urandom);
		it.duration_ticks = CNT_W'($urandom);
		it.red_in         = BYTE_W'($urandom);
		it.green_in       = BYTE_W'($urandom);
		it.blue_in        = BYTE_W'($urandom);
		send_beat(it);
	endtask

	task automatic send_pkt(input logic [BYTE_W-1:0] len, typ, input logic [CNT_W-1:0] dur,
			input logic [BYTE_W-1:0] r, g, b);
		in_item_t it;
		it.command        = CMD_PACKET;
		it.pkt_len        = len;
		it.msg_type       = typ;
		it.duration_ticks = dur;
		it.red_in         = r;
		it.green_in       = g;
		it.blue_in        = b;
		send_beat(it);
	endtask

	// mostly ticks and well-formed alerts, the rest short or foreign packets
	function automatic in_item_t rand_item();
		in_item_t it;
		int       pick;
		int       d;
		it.command        = CMD_TICK;
		it.pkt_len        = BYTE_W'($urandom_range(0, 250));
		it.msg_type       = BYTE_W'($urandom);
		it.duration_ticks = CNT_W'($urandom);
		it.red_in         = BYTE_W'($urandom);
		it.green_in       = BYTE_W'($urandom);
		it.blue_in        = BYTE_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick >= 50) begin
			it.command = CMD_PACKET;
			if (pick < 85) begin
				it.pkt_len  = BYTE_W'($urandom_range(6, 250));
				it.msg_type = cur_type;
				d = $urandom_range(0, 99);
				if (d < 6)
					it.duration_ticks = '0;
				else if (d >= 10)
					it.duration_ticks = CNT_W'($urandom_range(1, 40));
			end else if (pick < 92) begin
				it.pkt_len  = BYTE_W'($urandom_range(0, 5));
				it.msg_type = cur_type;
			end else begin
				it.msg_type = cur_type ^ BYTE_W'($urandom_range(1, 255));
			end
		end
		return it;
	endfunction

	// drop valid and wait until every status beat has come back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (status_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_cfg(input logic [CNT_W-1:0] cool, on_t, off_t, hb,
			input logic [BYTE_W-1:0] typ);
		settle();
		write_reg(REG_COOLDOWN, cool);
		write_reg(REG_ON, on_t);
		write_reg(REG_OFF, off_t);
		write_reg(REG_HEARTBEAT, hb);
		write_reg(REG_ALERT_TYPE, {8'h00, typ});
		// unused index must leave everything alone
		write_reg(REG_SPARE, 16'hFFFF);
		cfg_we   <= 1'b0;
		cur_type  = typ;
	endtask

	// receiver: ready, random and stalled stretches, plus one long hold-off
	initial begin : rx_pattern
		int mode;
		int left;
		int hold_left;
		bit rdy;
		m_axis_tready = 1'b0;
		mode      = 0;
		left      = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 300;
				rdy       = 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 60);
				end
				left--;
				case (mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					2: rdy = ($urandom_range(0, 3) != 0);
					default: rdy = 1'b0;
				endcase
			end
			m_axis_tready <= rdy;
		end
	end

	// stimulus and verdict
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_TICK;
		cfg_we        = 1'b0;
		cfg_index     = REG_COOLDOWN;
		cfg_wdata     = '0;
		burst_left    = 0;
		hold_req      = 1'b0;
		cur_type      = RST_ALERT_TYPE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// valid alert inside the first cooldown window is dropped
		send_pkt(8'd6, RST_ALERT_TYPE, 16'd5, 8'h11, 8'h22, 8'h33);
		send_tick();

		set_cfg(16'd0, 16'd2, 16'd1, 16'd3, 8'hA5);
		send_pkt(8'd5, 8'hA5, 16'd3, 8'h01, 8'h02, 8'h03);   // too short
		send_pkt(8'd6, 8'h00, 16'd3, 8'h01, 8'h02, 8'h03);   // wrong type
		send_pkt(8'd6, 8'hFF, 16'd3, 8'h01, 8'h02, 8'h03);   // wrong type
		send_pkt(8'd250, 8'hA5, 16'd0, 8'h00, 8'h00, 8'h00); // zero duration
		send_pkt(8'd6, 8'hA5, 16'd6, 8'hFF, 8'h00, 8'h80);
		repeat (7) send_tick();                              // lit, dark, end, heartbeat
		send_pkt(8'd200, 8'hA5, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
		send_tick();
		send_pkt(8'd0, 8'hA5, 16'd1, 8'h55, 8'hAA, 8'h55);   // empty packet

		// cooldown holds off the first alert, the second gets through; zero on/off and heartbeat periods
		set_cfg(16'd3, 16'd0, 16'd0, 16'd0, 8'h01);
		send_pkt(8'd6, 8'h01, 16'd2, 8'h12, 8'h34, 8'h56);
		repeat (3) send_tick();
		send_pkt(8'd6, 8'h01, 16'd2, 8'hED, 8'hCB, 8'hA9);
		repeat (3) send_tick();

		// random phases under several register settings
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_cfg(16'd0, 16'd0, 16'd0, 16'd0, 8'h00);
				2: set_cfg(16'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
				4: set_cfg(CNT_W'($urandom_range(0, 10)), 16'd0,
					CNT_W'($urandom_range(0, 8)), 16'd0, BYTE_W'($urandom));
				default: set_cfg(CNT_W'($urandom_range(0, 20)), CNT_W'($urandom_range(1, 8)),
					CNT_W'($urandom_range(1, 8)), CNT_W'($urandom_range(1, 15)),
					BYTE_W'($urandom));
			endcase
			// long receiver hold-off while the sender keeps offering
			if (ph == 1)
				hold_req = 1'b1;
			repeat (PHASE_BEATS) send_beat(rand_item());
		end

		// closing run: the flash runs out, then the cooldown expires for a second alert
		set_cfg(16'd30, 16'd3, 16'hFFFF, 16'hFFFF, BYTE_W'($urandom));
		send_pkt(8'd6, cur_type, 16'd10, 8'h0F, 8'hF0, 8'h3C);
		repeat (SOAK_TICKS) send_tick();
		send_pkt(8'd6, cur_type, 16'd10, 8'hC3, 8'h5A, 8'hA5);
		repeat (20) send_tick();

		settle();
		repeat (8) @(posedge clk);
		if (status_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
